// ----- src/ilp_pkg.sv -----
// ----------------------------------------------------------------------------
// Integer literal parser package
// Shared types, character constants and suffix tables for the literal parser.
// ----------------------------------------------------------------------------
package ilp_pkg;

    localparam int CharWidth  = 8;
    localparam int ValueWidth = 63;
    localparam int TypeWidth  = 3;
    localparam int ProdWidth  = ValueWidth + 4;
    localparam int SumWidth   = ValueWidth + 5;

    localparam logic [CharWidth-1:0] CHAR_0     = 8'h30;
    localparam logic [CharWidth-1:0] CHAR_9     = 8'h39;
    localparam logic [CharWidth-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CharWidth-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CharWidth-1:0] CHAR_A     = 8'h61;
    localparam logic [CharWidth-1:0] CHAR_F     = 8'h66;
    localparam logic [CharWidth-1:0] CHAR_X     = 8'h78;
    localparam logic [CharWidth-1:0] CHAR_B     = 8'h62;
    localparam logic [CharWidth-1:0] CHAR_O     = 8'h6F;
    localparam logic [CharWidth-1:0] CHAR_I     = 8'h69;
    localparam logic [CharWidth-1:0] CHAR_U     = 8'h75;
    localparam logic [CharWidth-1:0] CHAR_S     = 8'h73;
    localparam logic [CharWidth-1:0] CHAR_Z     = 8'h7A;
    localparam logic [CharWidth-1:0] CHAR_E     = 8'h65;
    localparam logic [CharWidth-1:0] CHAR_3     = 8'h33;
    localparam logic [CharWidth-1:0] CHAR_2     = 8'h32;
    localparam logic [CharWidth-1:0] CHAR_UNDER = 8'h5F;
    localparam logic [CharWidth-1:0] CHAR_NONE  = 8'h00;

    localparam logic [TypeWidth-1:0] TYPE_NONE  = 3'd0;
    localparam logic [TypeWidth-1:0] TYPE_USIZE = 3'd4;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_BIN = 2'd2,
        RADIX_OCT = 2'd3
    } radix_t;

    typedef struct packed {
        logic                  is_digit;
        logic                  ovf;
        logic [ValueWidth-1:0] acc;
    } digit_res_t;

    typedef struct packed {
        logic                  emit;
        logic [ValueWidth-1:0] value;
        logic [TypeWidth-1:0]  type_code;
        logic                  ovf;
    } lit_result_t;

    function automatic logic [CharWidth-1:0] lower_of(input logic [CharWidth-1:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    // Suffixes in order: i32, u32, isize, usize.
    function automatic logic [2:0] suffix_len(input logic [1:0] k);
        return k[1] ? 3'd5 : 3'd3;
    endfunction

    function automatic logic [CharWidth-1:0] suffix_char(input logic [1:0] k,
                                                         input logic [2:0] idx);
        logic [CharWidth-1:0] c;
        c = CHAR_NONE;
        unique case (idx)
            3'd0:    c = k[0] ? CHAR_U : CHAR_I;
            3'd1:    c = k[1] ? CHAR_S : CHAR_3;
            3'd2:    c = k[1] ? CHAR_I : CHAR_2;
            3'd3:    c = CHAR_Z;
            3'd4:    c = CHAR_E;
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

endpackage

// ----- src/ilp_digit_acc.sv -----
// ----------------------------------------------------------------------------
// Digit accumulator
// Classifies one character as a digit of the selected base and forms the
// shift-and-add update of the accumulated value with its overflow check.
// ----------------------------------------------------------------------------
module ilp_digit_acc import ilp_pkg::*; (
    input  logic [CharWidth-1:0]  char_code,
    input  radix_t                radix,
    input  logic [ValueWidth-1:0] acc,
    output digit_res_t            res
);

    logic [CharWidth-1:0] lc;
    logic [CharWidth-1:0] off;
    logic [4:0]           digit;
    logic                 valid;
    logic [ProdWidth-1:0] acc_w;
    logic [ProdWidth-1:0] prod;
    logic [SumWidth-1:0]  sum;

    always_comb begin
        lc    = lower_of(char_code);
        digit = 5'd16;
        off   = '0;
        if (char_code >= CHAR_0 && char_code <= CHAR_9) begin
            off   = char_code - CHAR_0;
            digit = {1'b0, off[3:0]};
        end else if (lc >= CHAR_A && lc <= CHAR_F) begin
            off   = lc - CHAR_A + 8'd10;
            digit = {1'b0, off[3:0]};
        end

        acc_w = {4'b0000, acc};
        unique case (radix)
            RADIX_HEX: begin
                valid = !digit[4];
                prod  = acc_w << 4;
            end
            RADIX_BIN: begin
                valid = digit < 5'd2;
                prod  = acc_w << 1;
            end
            RADIX_OCT: begin
                valid = digit < 5'd8;
                prod  = acc_w << 3;
            end
            default: begin
                valid = digit < 5'd10;
                prod  = (acc_w << 3) + (acc_w << 1);
            end
        endcase

        sum          = {1'b0, prod} + SumWidth'(digit[3:0]);
        res.is_digit = valid;
        res.ovf      = |sum[SumWidth-1:ValueWidth];
        res.acc      = sum[ValueWidth-1:0];
    end

endmodule

// ----- src/ilp_lexer_core.sv -----
// ----------------------------------------------------------------------------
// Literal lexer core
// Holds the per-literal state and applies one character per step, giving
// the finished result on the step that ends a literal.
// ----------------------------------------------------------------------------
module ilp_lexer_core import ilp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [CharWidth-1:0] char_code,
    input  logic                 is_last,
    input  logic                 empty_literal,
    output lit_result_t          result
);

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_DIGITS = 2'd1,
        PH_SUFFIX = 2'd2
    } phase_t;

    phase_t                phase_reg,  phase_next,  phase_eff;
    logic [1:0]            pos_reg,    pos_next;
    radix_t                radix_reg,  radix_next,  radix_eff;
    radix_t                prefix_reg, prefix_next;
    logic [ValueWidth-1:0] acc_reg,    acc_next,    acc_eff;
    logic                  seen_reg,   seen_next,   seen_eff;
    logic                  ovf_reg,    ovf_next,    ovf_eff;
    logic [3:0]            cand_reg,   cand_next,   cand_fed;
    logic [2:0]            slen_reg,   slen_next,   slen_fed;
    logic                  pending;
    logic                  take_prefix;
    logic [CharWidth-1:0]  lc;
    logic [TypeWidth-1:0]  type_sel;
    digit_res_t            dres;

    ilp_digit_acc u_digit_acc (
        .char_code (char_code),
        .radix     (radix_eff),
        .acc       (acc_eff),
        .res       (dres)
    );

    always_comb begin
        pending   = prefix_reg != RADIX_DEC;
        radix_eff = pending ? prefix_reg : radix_reg;
        acc_eff   = pending ? '0 : acc_reg;
        seen_eff  = pending ? 1'b0 : seen_reg;
        ovf_eff   = pending ? 1'b0 : ovf_reg;
        phase_eff = pending ? PH_DIGITS : phase_reg;
        lc        = lower_of(char_code);

        take_prefix = !pending && pos_reg == 2'd1 && phase_reg == PH_DIGITS && seen_reg
                      && acc_reg == '0 && !is_last
                      && (lc == CHAR_X || lc == CHAR_B || lc == CHAR_O);

        cand_fed = cand_reg;
        for (int k = 0; k < 4; k++) begin
            if (slen_reg >= suffix_len(2'(k)) || suffix_char(2'(k), slen_reg) != char_code) begin
                cand_fed[k] = 1'b0;
            end
        end
        slen_fed = (slen_reg == 3'd7) ? slen_reg : slen_reg + 3'd1;

        phase_next  = phase_eff;
        radix_next  = radix_eff;
        acc_next    = acc_eff;
        seen_next   = seen_eff;
        ovf_next    = ovf_eff;
        cand_next   = cand_reg;
        slen_next   = slen_reg;
        prefix_next = RADIX_DEC;
        pos_next    = (pos_reg == 2'd3) ? pos_reg : pos_reg + 2'd1;

        if (take_prefix) begin
            prefix_next = (lc == CHAR_X) ? RADIX_HEX : (lc == CHAR_B) ? RADIX_BIN : RADIX_OCT;
        end else if (phase_eff == PH_SUFFIX) begin
            cand_next = cand_fed;
            slen_next = slen_fed;
        end else begin
            phase_next = PH_DIGITS;
            if (char_code != CHAR_UNDER) begin
                if (!dres.is_digit) begin
                    phase_next = PH_SUFFIX;
                    cand_next  = cand_fed;
                    slen_next  = slen_fed;
                end else begin
                    seen_next = 1'b1;
                    if (!ovf_eff) begin
                        if (dres.ovf) begin
                            ovf_next = 1'b1;
                        end else begin
                            acc_next = dres.acc;
                        end
                    end
                end
            end
        end

        type_sel = TYPE_NONE;
        for (int k = 0; k < 4; k++) begin
            if (cand_next[k] && slen_next == suffix_len(2'(k))) begin
                type_sel = TypeWidth'(k + 1);
            end
        end

        result.emit      = is_last || empty_literal;
        result.value     = (empty_literal || !seen_next || ovf_next) ? '0 : acc_next;
        result.type_code = (empty_literal || !seen_next) ? TYPE_NONE : type_sel;
        result.ovf       = !empty_literal && seen_next && ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && (is_last || empty_literal))) begin
            phase_reg  <= PH_START;
            pos_reg    <= '0;
            radix_reg  <= RADIX_DEC;
            prefix_reg <= RADIX_DEC;
            acc_reg    <= '0;
            seen_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
            cand_reg   <= 4'hF;
            slen_reg   <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            radix_reg  <= radix_next;
            prefix_reg <= prefix_next;
            acc_reg    <= acc_next;
            seen_reg   <= seen_next;
            ovf_reg    <= ovf_next;
            cand_reg   <= cand_next;
            slen_reg   <= slen_next;
        end
    end

endmodule

// ----- src/integer_literal_parser.sv -----
// ----------------------------------------------------------------------------
// Integer literal parser
// Reads an integer literal one character per item and returns its value,
// suffix type and overflow flag when the literal ends.
//
// The input channel (s_) carries one character per item; s_is_last marks the
// final character and s_empty_literal stands for a literal of no characters.
// The result channel (m_) carries one item per literal.
// An accepted item is held in an input register and processed from there into
// the output register, so a result is offered on m_valid from the output register
// once the character that ends its literal has passed through the input register.
// One item is accepted every cycle while the result side keeps up; the
// accumulate step sets this rate.
// When the receiver stalls, the finished result waits in the output register
// and characters that do not end a literal keep flowing; once a final or empty
// item reaches the input register, s_ready falls until the result is taken.
// Reset empties both registers and discards any literal in progress.
// ----------------------------------------------------------------------------
module integer_literal_parser import ilp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CharWidth-1:0]  s_char_code,
    input  logic                  s_is_last,
    input  logic                  s_empty_literal,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ValueWidth-1:0] m_literal_value,
    output logic [TypeWidth-1:0]  m_type_code,
    output logic                  m_overflow
);

    logic                  in_valid_reg;
    logic [CharWidth-1:0]  in_char_reg;
    logic                  in_last_reg;
    logic                  in_empty_reg;
    logic                  out_valid_reg;
    logic [ValueWidth-1:0] out_value_reg;
    logic [TypeWidth-1:0]  out_type_reg;
    logic                  out_ovf_reg;
    logic                  out_free;
    logic                  advance;
    lit_result_t           core_res;

    ilp_lexer_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .char_code     (in_char_reg),
        .is_last       (in_last_reg),
        .empty_literal (in_empty_reg),
        .result        (core_res)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!core_res.emit || out_free);
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            in_char_reg  <= s_char_code;
            in_last_reg  <= s_is_last;
            in_empty_reg <= s_empty_literal;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && core_res.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && core_res.emit) begin
            out_value_reg <= core_res.value;
            out_type_reg  <= core_res.type_code;
            out_ovf_reg   <= core_res.ovf;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_literal_value = out_value_reg;
    assign m_type_code     = out_type_reg;
    assign m_overflow      = out_ovf_reg;

    a_emit_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && core_res.emit |=> out_valid_reg)
        else $error("finished item did not reach the output register");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && core_res.emit && out_valid_reg && !m_ready)
        else $error("input stalled without a waiting result");

    a_overflow_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_ovf_reg |-> out_value_reg == '0)
        else $error("overflowed item carries a non-zero value");

    a_type_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_type_reg <= TYPE_USIZE)
        else $error("type code out of range");

endmodule
